>>> hw/rtl/ir_range_linearize_and_smooth_defines.svh
// assertion macros shared by the range linearizer checkers
`ifndef IR_RANGE_LINEARIZE_AND_SMOOTH_DEFINES_SVH
`define IR_RANGE_LINEARIZE_AND_SMOOTH_DEFINES_SVH

// plain clocked property with synchronous reset masking
`define IRLS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// a stalled channel keeps valid high and its payload unchanged
`define IRLS_ASSERT_HOLD(lbl, clk, rst, v, r, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (v && !r) |=> (v && $stable(sig))) else $error(msg);

`endif

>>> hw/rtl/irls_pkg.sv
// shared widths, constants and segment tables for the range linearizer
package irls_pkg;

  localparam int VOLT_W    = 19;  // volts, Q3.16
  localparam int DIST_W    = 20;  // metres, Q4.16
  localparam int SMOOTH_W  = 24;
  localparam int COEF_W    = 17;  // Q1.16
  localparam int WCNT_W    = 4;
  localparam int FRAC_W    = 16;
  localparam int THR_N     = 10;
  localparam int SEG_N     = 9;
  localparam int SEG_W     = 4;
  localparam int SLOPE_W   = 28;
  localparam int NUMD_W    = 46;  // distance numerator incl. rounding term
  localparam int DEN_E8_W  = 27;
  localparam int EA_W      = SMOOTH_W + 1;  // signed sample minus smoothed value

  localparam logic [DEN_E8_W-1:0] DEN_E8     = 27'd100000000;
  localparam logic [NUMD_W-1:0]   HALF_E8    = 46'd50000000;
  localparam logic [DIST_W-1:0]   DIST_MAX   = 20'd655359;
  localparam logic [DIST_W-1:0]   DIST_FAR   = 20'd654705;
  localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 24'hFFFFFF;
  localparam logic [COEF_W-1:0]   COEF_ONE   = 17'd65536;
  localparam logic [COEF_W-1:0]   COEF_RESET = 17'd6554;
  localparam logic [FRAC_W-1:0]   FRAC_HALF  = 16'h8000;

  typedef logic [VOLT_W-1:0]  volt_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [SLOPE_W-1:0] seg_coef_t;

  // segment thresholds in volts, Q16
  localparam volt_t THR [THR_N] = '{
    19'd25187,  19'd28194,  19'd32329,  19'd38720,  19'd47366,
    19'd58644,  19'd84207,  19'd106386, 19'd150369, 19'd205254
  };

  // slope magnitude and intercept per segment, 1e-6 cm units
  localparam seg_coef_t SLOPE [SEG_N] = '{
    28'd217916667, 28'd158484848, 28'd102549020, 28'd75797101, 28'd58111111,
    28'd25637255,  28'd14774011,  28'd7450142,   28'd5970320
  };

  localparam seg_coef_t ICPT [SEG_N] = '{
    28'd163750000, 28'd138181818, 28'd110588235, 28'd94782609, 28'd82000000,
    28'd52941176,  28'd38983051,  28'd27094017,  28'd23698630
  };

endpackage

>>> hw/rtl/irls_if.sv
// handshake channel interfaces for the range linearizer

interface irls_sample_if #(parameter int ADC_BITS = 10);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  modport source (output valid, adc_sample, input ready);
  modport sink   (input valid, adc_sample, output ready);
endinterface

interface irls_result_if;
  logic                        valid;
  logic                        ready;
  logic [irls_pkg::DIST_W-1:0] filtered_distance;
  logic [irls_pkg::DIST_W-1:0] raw_distance;
  logic                        settled;
  modport source (output valid, filtered_distance, raw_distance, settled, input ready);
  modport sink   (input valid, filtered_distance, raw_distance, settled, output ready);
endinterface

interface irls_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [irls_pkg::COEF_W-1:0] smoothing_coefficient;
  modport source (output valid, smoothing_coefficient, input ready);
  modport sink   (input valid, smoothing_coefficient, output ready);
endinterface

>>> hw/rtl/ir_range_linearize_and_smooth.sv
// top level: ir range sensor linearizer with warm-up average and exponential smoothing
//
// samples (sink): one converter code per transfer; full scale code is 5 V.
// results (source): filtered_distance and raw_distance in metres Q4.16, plus
//   settled, which goes high once the first WARMUP_SAMPLES samples are averaged.
// cfg (sink): writes smoothing_coefficient, Q1.16 weight of the new sample;
//   values above 1.0 act as 1.0. always ready; write only while idle.
// stages: each runs on a bit-serial unit retiring one bit per cycle: volts
//   divide 19 bits, slope multiply 19 bits, metres divide 20 bits, then
//   warm-up divide 20 bits or smoothing multiply 17 bits. samples outside the
//   table skip the multiply and the metres divide.
// occupancy: one sample in flight; samples.ready is high only while idle, so
//   a new sample is taken only after the last result is committed.
// reset: synchronous, clears the smoothed value, warm-up count and output
//   valid, and loads the coefficient with about 0.1.
// stall: the result waits in the output register while results.ready is low;
//   the next sample is still taken and worked on, and its finished result
//   waits until the register frees before the state is committed.
module ir_range_linearize_and_smooth #(
  parameter int ADC_BITS       = 10,
  parameter int WARMUP_SAMPLES = 10
) (
  input logic            clk,
  input logic            rst,
  irls_sample_if.sink    samples,
  irls_result_if.source  results,
  irls_cfg_if.sink       cfg
);

  // volts numerator: code * 5 * 2^16 + floor(full / 2)
  localparam int FULL    = 2 ** ADC_BITS - 1;
  localparam int VNUM_W  = ADC_BITS + 19;
  localparam int C5_W    = ADC_BITS + 3;
  localparam int DPROD_W = irls_pkg::SLOPE_W + 1 + irls_pkg::VOLT_W;
  localparam int DIFF_W  = DPROD_W + 1;
  localparam int EP_W    = irls_pkg::EA_W + irls_pkg::COEF_W;
  localparam int T_W     = EP_W + 1;
  localparam int WNUM_W  = irls_pkg::DIST_W + 1;
  localparam int WS_W    = irls_pkg::SMOOTH_W + 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_VOLT = 10'b0000000010,
    S_SEG  = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_SUB  = 10'b0000010000,
    S_DDIV = 10'b0000100000,
    S_FILT = 10'b0001000000,
    S_WDIV = 10'b0010000000,
    S_EMA  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // control state
  logic [irls_pkg::SMOOTH_W-1:0] smooth;
  logic [irls_pkg::WCNT_W-1:0]   warm;
  logic [irls_pkg::COEF_W-1:0]   coef;

  // per-sample work registers
  irls_pkg::dist_t               raw;
  logic signed [DIFF_W-1:0]      diff;
  logic [irls_pkg::SMOOTH_W-1:0] pend_s;
  logic                          pend_settled;

  logic in_xfer, out_free, out_load;
  logic vdiv_start, dmul_start, ddiv_start, wdiv_start, emul_start;
  logic vdiv_done, dmul_done, ddiv_done, wdiv_done, emul_done;

  logic [ADC_BITS-1:0]           code;
  logic [C5_W-1:0]               code5;
  logic [VNUM_W-1:0]             vnum;
  irls_pkg::volt_t               volts;
  logic [irls_pkg::SEG_W-1:0]    seg;
  logic                          in_table, below;
  logic signed [DPROD_W-1:0]     dprod;
  logic                          diff_pos;
  logic [irls_pkg::NUMD_W-1:0]   dnum;
  irls_pkg::dist_t               dquo;
  logic                          warming;
  logic [WNUM_W-1:0]             wnum;
  irls_pkg::dist_t               wquo;
  logic [WS_W-1:0]               wsum;
  logic [irls_pkg::COEF_W-1:0]   coef_eff;
  logic signed [irls_pkg::EA_W-1:0] ediff;
  logic signed [EP_W-1:0]        eprod;
  logic [T_W-1:0]                tsum;

  assign in_xfer       = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign out_free      = !results.valid || results.ready;

  // front end: code to volts
  assign code  = ADC_BITS'(samples.adc_sample);
  assign code5 = C5_W'({code, 2'b00}) + C5_W'(code);
  assign vnum  = {code5, irls_pkg::FRAC_W'(0)} + VNUM_W'(FULL / 2);

  irls_sdiv #(.NUM_W(VNUM_W), .DEN_W(ADC_BITS), .Q_W(irls_pkg::VOLT_W)) u_volt_div (
    .clk   (clk),
    .rst   (rst),
    .start (vdiv_start),
    .num   (vnum),
    .den   (ADC_BITS'(FULL)),
    .done  (vdiv_done),
    .quo   (volts)
  );

  // segment lookup; volts holds steady until the next sample starts
  always_comb begin
    below    = volts < irls_pkg::THR[0];
    in_table = !below && (volts < irls_pkg::THR[irls_pkg::THR_N-1]);
    seg      = '0;
    for (int k = 1; k < irls_pkg::SEG_N; k++) begin
      if (volts >= irls_pkg::THR[k]) begin
        seg = irls_pkg::SEG_W'(k);
      end
    end
  end

  irls_smul #(.A_W(irls_pkg::SLOPE_W + 1), .B_W(irls_pkg::VOLT_W)) u_slope_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (dmul_start),
    .mcand  ($signed({1'b0, irls_pkg::SLOPE[seg]})),
    .mplier (volts),
    .done   (dmul_done),
    .prod   (dprod)
  );

  // intercept * 2^16 - slope * volts, rounded division by 1e8 gives Q16 metres
  assign diff_pos = !diff[DIFF_W-1] && (diff != '0);
  assign dnum     = diff[irls_pkg::NUMD_W-1:0] + irls_pkg::HALF_E8;

  irls_sdiv #(.NUM_W(irls_pkg::NUMD_W), .DEN_W(irls_pkg::DEN_E8_W),
              .Q_W(irls_pkg::DIST_W)) u_dist_div (
    .clk   (clk),
    .rst   (rst),
    .start (ddiv_start),
    .num   (dnum),
    .den   (irls_pkg::DEN_E8),
    .done  (ddiv_done),
    .quo   (dquo)
  );

  // warm-up: add round(raw / WARMUP_SAMPLES)
  assign warming = warm < irls_pkg::WCNT_W'(WARMUP_SAMPLES);
  assign wnum    = WNUM_W'(raw) + WNUM_W'(WARMUP_SAMPLES / 2);
  assign wsum    = WS_W'(smooth) + WS_W'(wquo);

  irls_sdiv #(.NUM_W(WNUM_W), .DEN_W(irls_pkg::WCNT_W), .Q_W(irls_pkg::DIST_W)) u_warm_div (
    .clk   (clk),
    .rst   (rst),
    .start (wdiv_start),
    .num   (wnum),
    .den   (irls_pkg::WCNT_W'(WARMUP_SAMPLES)),
    .done  (wdiv_done),
    .quo   (wquo)
  );

  // moving average as s * 2^16 + r * (raw - s), never negative
  assign coef_eff = (coef > irls_pkg::COEF_ONE) ? irls_pkg::COEF_ONE : coef;
  assign ediff    = irls_pkg::EA_W'(raw) - irls_pkg::EA_W'(smooth);
  assign tsum     = T_W'(eprod) + T_W'({smooth, irls_pkg::FRAC_HALF});

  irls_smul #(.A_W(irls_pkg::EA_W), .B_W(irls_pkg::COEF_W)) u_ema_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (emul_start),
    .mcand  (ediff),
    .mplier (coef_eff),
    .done   (emul_done),
    .prod   (eprod)
  );

  // sequencer
  always_comb begin
    state_next = state;
    vdiv_start = 1'b0;
    dmul_start = 1'b0;
    ddiv_start = 1'b0;
    wdiv_start = 1'b0;
    emul_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          vdiv_start = 1'b1;
          state_next = S_VOLT;
        end
      end
      S_VOLT: begin
        if (vdiv_done) state_next = S_SEG;
      end
      S_SEG: begin
        if (in_table) begin
          dmul_start = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_FILT;
        end
      end
      S_MUL: begin
        if (dmul_done) state_next = S_SUB;
      end
      S_SUB: begin
        if (diff_pos) begin
          ddiv_start = 1'b1;
          state_next = S_DDIV;
        end else begin
          state_next = S_FILT;
        end
      end
      S_DDIV: begin
        if (ddiv_done) state_next = S_FILT;
      end
      S_FILT: begin
        if (warming) begin
          wdiv_start = 1'b1;
          state_next = S_WDIV;
        end else begin
          emul_start = 1'b1;
          state_next = S_EMA;
        end
      end
      S_WDIV: begin
        if (wdiv_done) state_next = S_DONE;
      end
      S_EMA: begin
        if (emul_done) state_next = S_DONE;
      end
      S_DONE: begin
        // commit only once the output register can take the result
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
      smooth        <= '0;
      warm          <= '0;
      coef          <= irls_pkg::COEF_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        coef <= cfg.smoothing_coefficient;
      end
      if (out_load) begin
        results.valid <= 1'b1;
        smooth        <= pend_s;
        if (!pend_settled) begin
          warm <= warm + 1'b1;
        end
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_SEG && !in_table) begin
      raw <= below ? irls_pkg::DIST_FAR : '0;
    end
    if (state == S_MUL && dmul_done) begin
      diff <= DIFF_W'({irls_pkg::ICPT[seg], irls_pkg::FRAC_W'(0)}) - DIFF_W'(dprod);
    end
    if (state == S_SUB && !diff_pos) begin
      raw <= '0;
    end
    if (state == S_DDIV && ddiv_done) begin
      raw <= (dquo > irls_pkg::DIST_MAX) ? irls_pkg::DIST_MAX : dquo;
    end
    if (state == S_WDIV && wdiv_done) begin
      pend_s       <= wsum[WS_W-1] ? irls_pkg::SMOOTH_MAX : wsum[irls_pkg::SMOOTH_W-1:0];
      pend_settled <= 1'b0;
    end
    if (state == S_EMA && emul_done) begin
      pend_s       <= (|tsum[T_W-1:irls_pkg::FRAC_W+irls_pkg::SMOOTH_W]) ?
                      irls_pkg::SMOOTH_MAX :
                      tsum[irls_pkg::FRAC_W+irls_pkg::SMOOTH_W-1:irls_pkg::FRAC_W];
      pend_settled <= 1'b1;
    end
    if (out_load) begin
      results.filtered_distance <= (pend_s > irls_pkg::SMOOTH_W'(irls_pkg::DIST_MAX)) ?
                                   irls_pkg::DIST_MAX : pend_s[irls_pkg::DIST_W-1:0];
      results.raw_distance      <= raw;
      results.settled           <= pend_settled;
    end
  end

endmodule

>>> hw/rtl/irls_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
module irls_sdiv #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 10,
  parameter int Q_W   = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   sh;     // low numerator bits shift out, quotient bits shift in
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, sh[Q_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // top numerator bits are below den, so the quotient fits in Q_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(num >> Q_W);
      sh  <= num[Q_W-1:0];
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      sh  <= {sh[Q_W-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/irls_smul.sv
// bit-serial shift-add multiplier, signed multiplicand, msb-first unsigned multiplier
module irls_smul #(
  parameter int A_W = 29,
  parameter int B_W = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [A_W-1:0]  mcand,
  input  logic [B_W-1:0]         mplier,
  output logic                   done,
  output logic signed [A_W+B_W-1:0] prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic signed [A_W-1:0] areg;
  logic [B_W-1:0]        bsh;
  logic signed [P_W-1:0] acc;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [P_W-1:0]        addend;

  assign addend = bsh[B_W-1] ? P_W'(areg) : '0;
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= mcand;
      bsh  <= mplier;
      acc  <= '0;
    end else if (busy) begin
      acc <= (acc <<< 1) + addend;
      bsh <= {bsh[B_W-2:0], 1'b0};
    end
  end

endmodule

>>> hw/rtl/irls_checker.sv
// port-level checker for the range linearizer, bound to the top level
`include "ir_range_linearize_and_smooth_defines.svh"

module irls_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [irls_pkg::DIST_W-1:0] filtered_distance,
  input logic [irls_pkg::DIST_W-1:0] raw_distance,
  input logic                        settled
);

  logic [2*irls_pkg::DIST_W:0] out_pkt;
  logic                        out_xfer;
  logic                        in_xfer;
  logic                        seen_any;
  logic                        seen_settled;

  assign out_pkt  = {filtered_distance, raw_distance, settled};
  assign out_xfer = out_valid && out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any     <= 1'b0;
      seen_settled <= 1'b0;
    end else if (out_xfer) begin
      seen_any <= 1'b1;
      if (settled) begin
        seen_settled <= 1'b1;
      end
    end
  end

  `IRLS_ASSERT_HOLD(a_out_hold, clk, rst, out_valid, out_ready, out_pkt, "result changed while stalled")

  `IRLS_ASSERT(a_one_in_flight, clk, rst, in_xfer |=> !in_ready, "sample taken while one is in flight")

  `IRLS_ASSERT(a_first_unsettled, clk, rst, (out_xfer && !seen_any) |-> !settled, "first result already settled")

  `IRLS_ASSERT(a_settled_sticks, clk, rst, (out_xfer && seen_settled) |-> settled, "settled flag dropped")

endmodule

bind ir_range_linearize_and_smooth irls_checker u_irls_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (samples.valid),
  .in_ready          (samples.ready),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .filtered_distance (results.filtered_distance),
  .raw_distance      (results.raw_distance),
  .settled           (results.settled)
);
